// File: rtl/psrg_pkg.sv
`default_nettype none

package psrg_pkg;

    localparam int PT_W    = 12;
    localparam int SIZE_W  = 13;
    localparam int COL_W   = 14;
    localparam int H_W     = 32;
    localparam int COEF_W  = 36;
    localparam int NBR_N   = 6;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 32;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_SIZE_X  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_SIZE_Y  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_SIZE_Z  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_WRAP_X  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_WRAP_Y  = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_WRAP_Z  = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_SPACING = 3'd6;

    // neighbor slots, also the emit order
    localparam logic [2:0] NB_XM = 3'd0;
    localparam logic [2:0] NB_XP = 3'd1;
    localparam logic [2:0] NB_YM = 3'd2;
    localparam logic [2:0] NB_YP = 3'd3;
    localparam logic [2:0] NB_ZM = 3'd4;
    localparam logic [2:0] NB_ZP = 3'd5;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic              wrap_x;
        logic              wrap_y;
        logic              wrap_z;
        logic [H_W-1:0]    spacing;
    } t_cfg;

    typedef struct packed {
        logic [PT_W-1:0]   x;
        logic [PT_W-1:0]   y;
        logic [PT_W-1:0]   z;
        logic [COEF_W-1:0] diag;
        logic [NBR_N-1:0]  mask;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIAG,
        BK_NBR
    } t_bk_state;

endpackage

`default_nettype wire

// File: rtl/psrg_front.sv
`default_nettype none

module psrg_front (
    input  wire logic                   i_start,
    input  wire logic [11:0]            i_point_x,
    input  wire logic [11:0]            i_point_y,
    input  wire logic [11:0]            i_point_z,
    input  wire psrg_pkg::t_cfg         i_cfg,
    input  wire logic                   i_q_full,
    output logic                        o_busy,
    output logic                        o_push,
    output psrg_pkg::t_job              o_job
);
    import psrg_pkg::*;

    logic [COL_W-1:0] w_px, w_py, w_pz;
    logic [COL_W-1:0] w_sx1, w_sx2, w_sx3;
    logic [COL_W-1:0] w_sy1, w_sy2, w_sy3;
    logic [COL_W-1:0] w_sz1, w_sz2, w_sz3;
    logic             w_fx_lo, w_fx_hi, w_fy_lo, w_fy_hi, w_fz_lo, w_fz_hi;
    logic             w_pin;
    logic [2:0]       w_nface;
    logic [3:0]       w_factor;
    logic [NBR_N-1:0] w_mask;
    logic             w_h_zero;

    assign w_px = {2'b00, i_point_x};
    assign w_py = {2'b00, i_point_y};
    assign w_pz = {2'b00, i_point_z};

    // differences below zero wrap around and simply never match
    assign w_sx1 = {1'b0, i_cfg.size_x} - 14'd1;
    assign w_sx2 = {1'b0, i_cfg.size_x} - 14'd2;
    assign w_sx3 = {1'b0, i_cfg.size_x} - 14'd3;
    assign w_sy1 = {1'b0, i_cfg.size_y} - 14'd1;
    assign w_sy2 = {1'b0, i_cfg.size_y} - 14'd2;
    assign w_sy3 = {1'b0, i_cfg.size_y} - 14'd3;
    assign w_sz1 = {1'b0, i_cfg.size_z} - 14'd1;
    assign w_sz2 = {1'b0, i_cfg.size_z} - 14'd2;
    assign w_sz3 = {1'b0, i_cfg.size_z} - 14'd3;

    assign w_fx_lo = !i_cfg.wrap_x && (w_px == '0);
    assign w_fx_hi = !i_cfg.wrap_x && (w_px == w_sx1);
    assign w_fy_lo = !i_cfg.wrap_y && (w_py == '0);
    assign w_fy_hi = !i_cfg.wrap_y && (w_py == w_sy1);
    assign w_fz_lo = !i_cfg.wrap_z && (w_pz == '0);
    assign w_fz_hi = !i_cfg.wrap_z && (w_pz == w_sz1);

    assign w_pin    = (w_px == w_sx2) && (w_py == w_sy2) && (w_pz == w_sz2);
    assign w_h_zero = (i_cfg.spacing == '0);

    assign w_nface = {2'b00, w_fx_lo} + {2'b00, w_fx_hi} + {2'b00, w_fy_lo}
                   + {2'b00, w_fy_hi} + {2'b00, w_fz_lo} + {2'b00, w_fz_hi};
    assign w_factor = w_pin ? 4'd6 : (4'd6 + {1'b0, w_nface});

    always_comb begin
        w_mask[NB_XM] = !w_fx_lo &&
            !((w_pz == w_sz2) && (w_py == w_sy2) && (w_px == w_sx1));
        w_mask[NB_XP] = !w_fx_hi &&
            !((w_pz == w_sz2) && (w_py == w_sy2) && (w_px == w_sx3));
        w_mask[NB_YM] = !w_fy_lo &&
            !((w_pz == w_sz2) && (w_py == w_sy1) && (w_px == w_sx2));
        w_mask[NB_YP] = !w_fy_hi &&
            !((w_pz == w_sz2) && (w_py == w_sy3) && (w_px == w_sx2));
        w_mask[NB_ZM] = !w_fz_lo &&
            !((w_pz == w_sz1) && (w_py == w_sy2) && (w_px == w_sx2));
        w_mask[NB_ZP] = !w_fz_hi &&
            !((w_pz == w_sz3) && (w_py == w_sy2) && (w_px == w_sx2));
        if (w_pin || w_h_zero) begin
            w_mask = '0;
        end
    end

    assign o_busy      = i_q_full;
    assign o_push      = i_start && !i_q_full;
    assign o_job.x     = i_point_x;
    assign o_job.y     = i_point_y;
    assign o_job.z     = i_point_z;
    assign o_job.diag  = {4'b0000, i_cfg.spacing} * {32'd0, w_factor};
    assign o_job.mask  = w_mask;

endmodule

`default_nettype wire

// File: rtl/psrg_fifo.sv
`default_nettype none

module psrg_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire psrg_pkg::t_job     i_data,
    input  wire logic               i_pop,
    output psrg_pkg::t_job          o_head,
    output logic                    o_full,
    output logic                    o_empty
);
    import psrg_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (Q_PTR_W+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (Q_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/psrg_back.sv
`default_nettype none

module psrg_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [31:0]            i_spacing,
    input  wire psrg_pkg::t_job         i_head,
    input  wire logic                   i_q_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic signed [13:0]          o_col_x,
    output logic signed [13:0]          o_col_y,
    output logic signed [13:0]          o_col_z,
    output logic [35:0]                 o_coefficient,
    output logic                        o_last
);
    import psrg_pkg::*;

    t_bk_state         r_state, n_state;
    logic [PT_W-1:0]   r_x, r_y, r_z;
    logic [COEF_W-1:0] r_diag;
    logic [NBR_N-1:0]  r_mask, n_mask;
    logic              r_valid, n_valid;
    logic [COL_W-1:0]  r_cx, r_cy, r_cz, n_cx, n_cy, n_cz;
    logic [COEF_W-1:0] r_coef, n_coef;
    logic              r_last, n_last;
    logic [2:0]        w_sel;
    logic [COL_W-1:0]  w_x, w_y, w_z;
    logic              w_load;

    assign w_x = {2'b00, r_x};
    assign w_y = {2'b00, r_y};
    assign w_z = {2'b00, r_z};

    // lowest pending neighbor
    always_comb begin
        w_sel = NB_XM;
        for (int k = NBR_N - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                w_sel = 3'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_mask  = r_mask;
        n_valid = 1'b0;
        n_cx    = w_x;
        n_cy    = w_y;
        n_cz    = w_z;
        n_coef  = r_diag;
        n_last  = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                w_load = !i_q_empty;
            end
            BK_DIAG: begin
                n_valid = 1'b1;
                n_last  = (r_mask == '0);
                if (n_last) begin
                    w_load  = !i_q_empty;
                    n_state = BK_IDLE;
                end else begin
                    n_state = BK_NBR;
                end
            end
            BK_NBR: begin
                n_valid = 1'b1;
                n_coef  = {4'b0000, i_spacing};
                n_mask  = r_mask & ~(NBR_N'(1) << w_sel);
                case (w_sel)
                    NB_XM:   n_cx = w_x - 14'd1;
                    NB_XP:   n_cx = w_x + 14'd1;
                    NB_YM:   n_cy = w_y - 14'd1;
                    NB_YP:   n_cy = w_y + 14'd1;
                    NB_ZM:   n_cz = w_z - 14'd1;
                    NB_ZP:   n_cz = w_z + 14'd1;
                    default: n_cx = w_x;
                endcase
                n_last = (n_mask == '0);
                if (n_last) begin
                    w_load  = !i_q_empty;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        if (w_load) begin
            n_state = BK_DIAG;
            n_mask  = i_head.mask;
        end
    end

    assign o_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= 1'b0;
            r_mask  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_mask  <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x    <= i_head.x;
            r_y    <= i_head.y;
            r_z    <= i_head.z;
            r_diag <= i_head.diag;
        end
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_cz   <= n_cz;
        r_coef <= n_coef;
        r_last <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_col_x       = $signed(r_cx);
    assign o_col_y       = $signed(r_cy);
    assign o_col_z       = $signed(r_cz);
    assign o_coefficient = r_coef;
    assign o_last        = r_last;

    a_nbr_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_NBR |-> r_mask != '0)
        else $error("neighbor state with nothing pending");

    a_row_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |=> r_valid)
        else $error("gap inside a row");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: rtl/poisson_stencil_row_generator_core.sv
`default_nettype none

// channel    | handshake                  | payload
// -----------+----------------------------+----------------------------------------
// request    | i_start, o_busy            | i_point_x, i_point_y, i_point_z
// result     | o_valid (one-cycle strobe) | o_col_x/y/z, o_coefficient, o_last
// config     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A request yields 1 to 7 results, one per cycle (diagonal, then kept neighbors);
// the result port, at one entry per cycle, sets the sustained request rate.
// When the emitter is idle, a request passes the queue and the output registers;
// a two-deep queue lets requests be taken back to back; o_busy is high while it is full.
// Synchronous active-low reset clears control and loads register defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.

module poisson_stencil_row_generator_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    output logic                        o_busy,
    input  wire logic [11:0]            i_point_x,
    input  wire logic [11:0]            i_point_y,
    input  wire logic [11:0]            i_point_z,
    input  wire logic                   i_cfg_we,
    input  wire logic [2:0]             i_cfg_index,
    input  wire logic [31:0]            i_cfg_data,
    output logic                        o_valid,
    output logic signed [13:0]          o_col_x,
    output logic signed [13:0]          o_col_y,
    output logic signed [13:0]          o_col_z,
    output logic [35:0]                 o_coefficient,
    output logic                        o_last
);
    import psrg_pkg::*;

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_head;
    logic w_push, w_pop, w_full, w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_x  <= 13'd64;
            r_cfg.size_y  <= 13'd64;
            r_cfg.size_z  <= 13'd64;
            r_cfg.wrap_x  <= 1'b0;
            r_cfg.wrap_y  <= 1'b0;
            r_cfg.wrap_z  <= 1'b0;
            r_cfg.spacing <= 32'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SIZE_X:  r_cfg.size_x  <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:  r_cfg.size_y  <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:  r_cfg.size_z  <= i_cfg_data[SIZE_W-1:0];
                REG_WRAP_X:  r_cfg.wrap_x  <= i_cfg_data[0];
                REG_WRAP_Y:  r_cfg.wrap_y  <= i_cfg_data[0];
                REG_WRAP_Z:  r_cfg.wrap_z  <= i_cfg_data[0];
                REG_SPACING: r_cfg.spacing <= i_cfg_data;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    psrg_front u_front (
        .i_start   (i_start),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_cfg     (r_cfg),
        .i_q_full  (w_full),
        .o_busy    (o_busy),
        .o_push    (w_push),
        .o_job     (w_push_job)
    );

    psrg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    psrg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_spacing     (r_cfg.spacing),
        .i_head        (w_head),
        .i_q_empty     (w_empty),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .o_col_x       (o_col_x),
        .o_col_y       (o_col_y),
        .o_col_z       (o_col_z),
        .o_coefficient (o_coefficient),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire
